@@ rtl/core/cht_pkg.sv @@
// Shared types and constants for the coordinate hash table unit.
// Used by cht_ctrl, cht_datapath and coord_hash_table_unit; depends on nothing.
`default_nettype none

package cht_pkg;

   // Table geometry. BUCKETS must be a power of two.
   localparam int BUCKETS   = 4096;
   localparam int MAX_NODES = 1024;

   localparam int BUCKET_AW = $clog2(BUCKETS);
   localparam int NODE_AW   = $clog2(MAX_NODES);
   localparam int NODE_LW   = $clog2(MAX_NODES + 1);

   localparam int COORD_W   = 16;
   localparam int KEY_W     = 3 * COORD_W;
   localparam int SUM_W     = COORD_W + 5;
   localparam int HANDLE_W  = 10;
   localparam int ENTRY_W   = 11;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [2:0] {
      ST_ADDED   = 3'd0,
      ST_PRESENT = 3'd1,
      ST_FULL    = 3'd2,
      ST_FOUND   = 3'd3,
      ST_MISSING = 3'd4
   } status_type;

   typedef struct packed {
      logic                      opcode;
      logic signed [COORD_W-1:0] coord_x;
      logic signed [COORD_W-1:0] coord_y;
      logic signed [COORD_W-1:0] coord_z;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [HANDLE_W-1:0] handle;
      logic [ENTRY_W-1:0]  entry_count;
   } rsp_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic clear;
      logic hash_sum;
      logic hash_bucket;
      logic link_init;
      logic step;
      logic hit;
      logic finish;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_last;
      logic walk_ok;
      logic key_match;
   } stat_type;

endpackage

`default_nettype wire

@@ rtl/core/cht_datapath.sv @@
// Datapath of the coordinate hash table: hash, bucket and node memories, chain walk registers.
// Depends on cht_pkg; driven by commands from cht_ctrl.
`default_nettype none

module cht_datapath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cht_pkg::req_type req_data,
   input  wire cht_pkg::cmd_type cmd,
   output cht_pkg::stat_type     stat,
   output logic                  rsp_strobe,
   output cht_pkg::rsp_type      rsp_data
);
   import cht_pkg::*;

   logic [NODE_LW-1:0] bucket_mem [BUCKETS];
   logic [KEY_W-1:0]   node_key_mem [MAX_NODES];
   logic [NODE_LW-1:0] node_next_mem [MAX_NODES];

   req_type                 key_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic [BUCKET_AW-1:0]    bucket_ff;
   logic [BUCKET_AW-1:0]    clear_ff;
   logic [NODE_LW-1:0]      head_q_ff;
   logic [KEY_W-1:0]        node_key_q_ff;
   logic [NODE_LW-1:0]      node_next_q_ff;
   logic [NODE_LW-1:0]      link_ff;
   logic [NODE_LW-1:0]      last_ff;
   logic [NODE_LW-1:0]      steps_ff;
   logic [NODE_LW-1:0]      count_ff;
   logic                    hit_ff;
   logic [NODE_AW-1:0]      hit_idx_ff;
   logic                    rsp_strobe_ff;
   rsp_type                 rsp_ff;

   logic signed [SUM_W-1:0] x_ext, y_ext, z_ext, sum_in;
   logic [SUM_W-1:0]        abs_sum;
   logic [NODE_LW-1:0]      link_m1, last_m1, count_p1;
   logic [NODE_AW-1:0]      link_idx, count_idx;
   logic                    room;
   logic                    do_add;
   logic                    bkt_we;
   logic [BUCKET_AW-1:0]    bkt_wa;
   logic [NODE_LW-1:0]      bkt_wd;
   logic                    nxt_we;
   logic [NODE_AW-1:0]      nxt_wa;
   logic [NODE_LW-1:0]      nxt_wd;
   rsp_type                 rsp_in;

   // 9x + 5y + 3z by shifts and adds; 21 bits cannot overflow for 16-bit inputs.
   always_comb begin
      x_ext  = SUM_W'(key_ff.coord_x);
      y_ext  = SUM_W'(key_ff.coord_y);
      z_ext  = SUM_W'(key_ff.coord_z);
      sum_in = (x_ext <<< 3) + x_ext + (y_ext <<< 2) + y_ext + (z_ext <<< 1) + z_ext;
      abs_sum = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
   end

   assign link_m1   = link_ff - NODE_LW'(1);
   assign last_m1   = last_ff - NODE_LW'(1);
   assign count_p1  = count_ff + NODE_LW'(1);
   assign link_idx  = link_m1[NODE_AW-1:0];
   assign count_idx = count_ff[NODE_AW-1:0];
   assign room      = count_ff < NODE_LW'(MAX_NODES);
   assign do_add    = cmd.finish && (key_ff.opcode == OP_INSERT) && !hit_ff && room;

   assign stat.clear_last = clear_ff == BUCKET_AW'(BUCKETS - 1);
   assign stat.walk_ok    = (link_ff != '0) && (link_ff <= count_ff)
                            && (link_ff <= NODE_LW'(MAX_NODES)) && (steps_ff < count_ff);
   assign stat.key_match  = node_key_q_ff == {key_ff.coord_x, key_ff.coord_y, key_ff.coord_z};

   // Bucket memory write: clearing pass, or the head of an empty chain.
   always_comb begin
      bkt_we = 1'b0;
      bkt_wa = bucket_ff;
      bkt_wd = count_p1;
      if (cmd.clear) begin
         bkt_we = 1'b1;
         bkt_wa = clear_ff;
         bkt_wd = '0;
      end else if (do_add && (last_ff == '0)) begin
         bkt_we = 1'b1;
      end
   end

   // Next-link write: the new node's link is cleared early in the walk, since
   // that node is not reachable yet; the tail link is written at the end.
   always_comb begin
      nxt_we = 1'b0;
      nxt_wa = last_m1[NODE_AW-1:0];
      nxt_wd = count_p1;
      if (cmd.hash_sum && room) begin
         nxt_we = 1'b1;
         nxt_wa = count_idx;
         nxt_wd = '0;
      end else if (do_add && (last_ff != '0)) begin
         nxt_we = 1'b1;
      end
   end

   always_comb begin
      rsp_in.entry_count = ENTRY_W'(count_ff);
      rsp_in.handle      = '0;
      if (key_ff.opcode == OP_LOOKUP) begin
         rsp_in.status = hit_ff ? ST_FOUND : ST_MISSING;
         if (hit_ff) begin
            rsp_in.handle = HANDLE_W'(hit_idx_ff);
         end
      end else if (hit_ff) begin
         rsp_in.status = ST_PRESENT;
         rsp_in.handle = HANDLE_W'(hit_idx_ff);
      end else if (!room) begin
         rsp_in.status = ST_FULL;
      end else begin
         rsp_in.status      = ST_ADDED;
         rsp_in.handle      = HANDLE_W'(count_idx);
         rsp_in.entry_count = ENTRY_W'(count_p1);
      end
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bucket_mem[bkt_wa] <= bkt_wd;
      end
      head_q_ff <= bucket_mem[bucket_ff];
   end

   always_ff @(posedge clock) begin
      if (do_add) begin
         node_key_mem[count_idx] <= {key_ff.coord_x, key_ff.coord_y, key_ff.coord_z};
      end
      node_key_q_ff <= node_key_mem[link_idx];
   end

   always_ff @(posedge clock) begin
      if (nxt_we) begin
         node_next_mem[nxt_wa] <= nxt_wd;
      end
      node_next_q_ff <= node_next_mem[link_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         key_ff <= req_data;
      end
      if (cmd.hash_sum) begin
         sum_ff <= sum_in;
      end
      if (cmd.hash_bucket) begin
         bucket_ff <= abs_sum[BUCKET_AW-1:0];
      end
      if (cmd.link_init) begin
         link_ff  <= head_q_ff;
         last_ff  <= '0;
         steps_ff <= '0;
      end else if (cmd.step) begin
         last_ff  <= link_ff;
         link_ff  <= node_next_q_ff;
         steps_ff <= steps_ff + NODE_LW'(1);
      end
      if (cmd.hit) begin
         hit_idx_ff <= link_idx;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= '0;
         count_ff      <= '0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.finish;
         if (cmd.clear) begin
            clear_ff <= clear_ff + BUCKET_AW'(1);
         end
         if (cmd.link_init) begin
            hit_ff <= 1'b0;
         end else if (cmd.hit) begin
            hit_ff <= 1'b1;
         end
         if (do_add) begin
            count_ff <= count_p1;
         end
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/cht_ctrl.sv @@
// Controller of the coordinate hash table: clearing pass, hashing and chain walk sequence.
// Depends on cht_pkg; commands cht_datapath.
`default_nettype none

module cht_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire cht_pkg::stat_type stat,
   output logic                   busy,
   output cht_pkg::cmd_type       cmd
);
   import cht_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_SUM,
      S_BKT,
      S_HRD,
      S_LINK,
      S_WALK,
      S_CMP,
      S_DONE
   } state_type;

   state_type state_ff;
   logic      busy_ff;

   always_comb begin
      cmd             = '0;
      cmd.load        = (state_ff == S_IDLE) && start;
      cmd.clear       = state_ff == S_CLEAR;
      cmd.hash_sum    = state_ff == S_SUM;
      cmd.hash_bucket = state_ff == S_BKT;
      cmd.link_init   = state_ff == S_LINK;
      cmd.hit         = (state_ff == S_CMP) && stat.key_match;
      cmd.step        = (state_ff == S_CMP) && !stat.key_match;
      cmd.finish      = state_ff == S_DONE;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         unique case (state_ff)
            S_CLEAR: begin
               if (stat.clear_last) begin
                  state_ff <= S_IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            S_IDLE: begin
               if (start) begin
                  state_ff <= S_SUM;
                  busy_ff  <= 1'b1;
               end
            end
            S_SUM:  state_ff <= S_BKT;
            S_BKT:  state_ff <= S_HRD;
            // The bucket memory read happens in this state.
            S_HRD:  state_ff <= S_LINK;
            S_LINK: state_ff <= S_WALK;
            S_WALK: begin
               state_ff <= stat.walk_ok ? S_CMP : S_DONE;
            end
            S_CMP: begin
               state_ff <= stat.key_match ? S_DONE : S_WALK;
            end
            S_DONE: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
            default: begin
               state_ff <= S_IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign busy = busy_ff;

endmodule

`default_nettype wire

@@ rtl/core/coord_hash_table_unit.sv @@
// Top level of the coordinate hash table: a set of 3D coordinates in a chained hash table.
// Depends on cht_pkg, cht_ctrl and cht_datapath.
//
// After reset the unit clears its 4096 bucket heads, one per cycle, and holds busy high
// until the clearing pass is done. A request transfers when start is high and busy is low;
// busy then stays high until the answer is out. A request steps through S_SUM, S_BKT,
// S_HRD and S_LINK, then an S_WALK and S_CMP pair per chain node read, and ends in S_DONE
// after a match or when no node is left. Busy falls at the edge that registers the answer,
// so the next request can transfer during the answer's cycle. The answer appears on
// rsp_data for one cycle with rsp_strobe high and must be taken then: the receiver cannot
// stall it. Exactly one answer comes back for every request.
`default_nettype none

module coord_hash_table_unit (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire cht_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output cht_pkg::rsp_type      rsp_data
);
   import cht_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   cht_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   cht_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
